// ----- hdl/geodetic_to_ecef_core_assert.svh -----
// Assertion helpers for the geodetic to ECEF core.
// Clock and reset names follow the house port names.
`ifndef GEODETIC_TO_ECEF_CORE_ASSERT_SVH
`define GEODETIC_TO_ECEF_CORE_ASSERT_SVH

// Same-cycle implication.
`define G2E_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("geodetic_to_ecef_core check failed");

// Next-cycle implication.
`define G2E_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("geodetic_to_ecef_core check failed");

`endif

// ----- hdl/g2e_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package g2e_pkg;

    localparam int DW     = 64;
    localparam int HALF   = 32;
    localparam int PROD_W = 128;

    localparam logic [DW-1:0] MASK63    = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] ONE_Q62   = 64'd1 << 62;
    localparam logic [DW-1:0] THREE_Q62 = 64'd3 << 62;
    localparam logic [DW-1:0] A_MM      = 64'd6378137000;
    localparam logic [DW-1:0] E2_NUM    = 64'd6694380004260827;
    localparam logic [DW-1:0] E2_DEN    = 64'd1000000000000000000;
    localparam int            RSQRT_STEPS = 7;

    localparam logic signed [31:0] LAT_MAX = 32'sd1073741824;
    localparam logic signed [31:0] LAT_MIN = -32'sd1073741824;
    localparam logic signed [32:0] LON_HALF = 33'sd2147483648;

    // round(a*b / 2^s), product wraps at 128 bits
    function automatic logic [DW-1:0] f_umul_sh(input logic [DW-1:0] a,
                                                input logic [DW-1:0] b,
                                                input int s);
        logic [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b);
        p = p + (PROD_W'(1) << (s - 1));
        return DW'(p >> s);
    endfunction

    // floor(n * 2^sh / d), long division one bit at a time
    function automatic logic [DW-1:0] f_div_sh(input logic [DW-1:0] n, input int sh,
                                               input logic [DW-1:0] d);
        logic [DW-1:0] r;
        logic [DW-1:0] q;
        logic [DW-1:0] b;
        int bit_i;
        r = '0;
        q = '0;
        for (bit_i = DW - 1 + sh; bit_i >= 0; bit_i--) begin
            b = '0;
            if (bit_i >= sh)
                b = (n >> (bit_i - sh)) & 64'd1;
            r = (r << 1) | b;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic logic [DW-1:0] f_rsqrt(input logic [DW-1:0] m);
        logic [DW-1:0] y;
        logic [DW-1:0] t;
        logic [DW-1:0] u;
        logic [DW-1:0] w;
        int k;
        y = ONE_Q62;
        for (k = 0; k < RSQRT_STEPS; k++) begin
            t = f_umul_sh(y, y, 62);
            u = f_umul_sh(m, t, 62);
            w = (u > THREE_Q62) ? '0 : THREE_Q62 - u;
            y = f_umul_sh(y, w, 63);
        end
        return y;
    endfunction

    // atan(2^-i) in Q62 from its series, i >= 1
    function automatic logic [DW-1:0] f_atan_pow2(input int i);
        logic [DW-1:0] sum;
        logic [DW-1:0] term;
        int k;
        sum = '0;
        for (k = 0; i * (2 * k + 1) <= 62; k++) begin
            term = f_div_sh(64'd1 << (62 - i * (2 * k + 1)), 0, DW'(2 * k + 1));
            sum = (k % 2 == 1) ? sum - term : sum + term;
        end
        return sum;
    endfunction

    function automatic logic [DW-1:0] f_quarter_pi();
        logic [DW-1:0] third;
        logic [DW-1:0] a13;
        logic [DW-1:0] term;
        int k;
        third = f_div_sh(ONE_Q62, 0, 64'd3);
        a13 = '0;
        k = 0;
        while (third != '0) begin
            term = f_div_sh(third, 0, DW'(2 * k + 1));
            a13 = (k % 2 == 1) ? a13 - term : a13 + term;
            third = f_div_sh(third, 0, 64'd9);
            k++;
        end
        return f_atan_pow2(1) + a13;
    endfunction

    // arctangent step in angle units, pi = 2^61
    function automatic logic [DW-1:0] f_atan_entry(input int i);
        if (i == 0)
            return 64'd1 << 59;
        return (f_div_sh(f_atan_pow2(i), 60, f_quarter_pi()) + 64'd1) >> 1;
    endfunction

    function automatic logic [DW-1:0] f_gain_inv(input int stages);
        logic [DW-1:0] p;
        int i;
        p = 64'd1 << 60;
        for (i = 0; i < stages; i++) begin
            if (2 * i < DW)
                p = p + (p >> (2 * i));
        end
        return (f_rsqrt(p) + 64'd1) >> 1;
    endfunction

    localparam logic [DW-1:0] E2_Q62 = (f_div_sh(E2_NUM, 63, E2_DEN) + 64'd1) >> 1;

endpackage
`default_nettype wire

// ----- hdl/geodetic_to_ecef_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// WGS84 geodetic to ECEF conversion, one position per clock. Latitude and
// longitude are binary angles (2^31 = pi), altitude and results are in mm.
// It is built from an input register, one CORDIC stage
// per iteration (latitude and longitude side by side), seven Newton steps of
// three pipelined 64x64 multipliers each for 1/sqrt, and a chain of rounded
// products; every multiplier is four 32x32 partial products over three
// stages, plus a magnitude and a sign stage where signed. The pipeline holds
// as a whole while a finished result waits, so a new item is taken on every
// cycle in which the output is not stalled.
`include "geodetic_to_ecef_core_assert.svh"
module geodetic_to_ecef_core
    import g2e_pkg::*;
#(
    parameter int CORDIC_STAGES = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_latitude,
    input  wire logic signed [31:0] i_longitude,
    input  wire logic signed [27:0] i_altitude,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [33:0]      o_ecef_x,
    output logic signed [33:0]      o_ecef_y,
    output logic signed [33:0]      o_ecef_z
);

    typedef struct packed {
        logic [DW-1:0] cl;
        logic [DW-1:0] sl;
        logic [DW-1:0] co;
        logic [DW-1:0] so;
        logic [27:0]   h;
    } t_base;

    typedef struct packed {
        logic [DW-1:0] m;
        logic [DW-1:0] y;
        t_base         base;
    } t_rs_side;

    typedef struct packed {
        logic [DW-1:0] m;
        t_base         base;
    } t_rc_side;

    typedef struct packed {
        logic [DW-1:0] r20;
        t_base         base;
    } t_r20_side;

    typedef struct packed {
        logic [DW-1:0] co;
        logic [DW-1:0] so;
        logic [DW-1:0] rzh;
        logic [DW-1:0] sl;
    } t_tm_side;

    typedef struct packed {
        logic [DW-1:0] t;
        logic [DW-1:0] so;
        logic [DW-1:0] rzh;
        logic [DW-1:0] sl;
    } t_xm_side;

    typedef struct packed {
        logic [33:0]   x;
        logic [DW-1:0] rzh;
        logic [DW-1:0] sl;
    } t_ym_side;

    typedef struct packed {
        logic [33:0] x;
        logic [33:0] y;
    } t_zm_side;

    localparam logic signed [DW-1:0] GAIN_INV = f_gain_inv(CORDIC_STAGES);
    localparam logic signed [DW-1:0] Z_LIM    = 64'sd1 <<< 60;

    logic en;

    // ---------------- input stage and CORDIC ----------------
    logic signed [DW-1:0] r_lx [0:CORDIC_STAGES];
    logic signed [DW-1:0] r_ly [0:CORDIC_STAGES];
    logic signed [DW-1:0] r_lz [0:CORDIC_STAGES];
    logic signed [DW-1:0] r_ox [0:CORDIC_STAGES];
    logic signed [DW-1:0] r_oy [0:CORDIC_STAGES];
    logic signed [DW-1:0] r_oz [0:CORDIC_STAGES];
    logic                 r_cf [0:CORDIC_STAGES];
    logic [27:0]          r_ch [0:CORDIC_STAGES];
    logic                 r_cv [0:CORDIC_STAGES];

    logic signed [31:0] n_lat;
    logic signed [32:0] n_lon33;
    logic signed [31:0] n_lon;
    logic               n_flip;

    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    always_comb begin
        n_lat = i_latitude;
        if (i_latitude > LAT_MAX)
            n_lat = LAT_MAX;
        else if (i_latitude < LAT_MIN)
            n_lat = LAT_MIN;
        // turn back-half longitudes by pi and negate the result later
        n_lon33 = 33'(i_longitude);
        n_flip  = 1'b0;
        if (i_longitude > LAT_MAX) begin
            n_lon33 = 33'(i_longitude) - LON_HALF;
            n_flip  = 1'b1;
        end else if (i_longitude < LAT_MIN) begin
            n_lon33 = 33'(i_longitude) + LON_HALF;
            n_flip  = 1'b1;
        end
        n_lon = n_lon33[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lx[0] <= GAIN_INV;
            r_ly[0] <= '0;
            r_lz[0] <= {{2{n_lat[31]}}, n_lat, 30'b0};
            r_ox[0] <= GAIN_INV;
            r_oy[0] <= '0;
            r_oz[0] <= {{2{n_lon[31]}}, n_lon, 30'b0};
            r_cf[0] <= n_flip;
            r_ch[0] <= i_altitude;
        end
    end

    generate
        for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
            localparam logic signed [DW-1:0] ATAN = f_atan_entry(i);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cv[i+1] <= 1'b0;
                end else if (en) begin
                    r_cv[i+1] <= r_cv[i];
                end
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (!r_lz[i][DW-1]) begin
                        r_lx[i+1] <= r_lx[i] - (r_ly[i] >>> i);
                        r_ly[i+1] <= r_ly[i] + (r_lx[i] >>> i);
                        r_lz[i+1] <= r_lz[i] - ATAN;
                    end else begin
                        r_lx[i+1] <= r_lx[i] + (r_ly[i] >>> i);
                        r_ly[i+1] <= r_ly[i] - (r_lx[i] >>> i);
                        r_lz[i+1] <= r_lz[i] + ATAN;
                    end
                    if (!r_oz[i][DW-1]) begin
                        r_ox[i+1] <= r_ox[i] - (r_oy[i] >>> i);
                        r_oy[i+1] <= r_oy[i] + (r_ox[i] >>> i);
                        r_oz[i+1] <= r_oz[i] - ATAN;
                    end else begin
                        r_ox[i+1] <= r_ox[i] + (r_oy[i] >>> i);
                        r_oy[i+1] <= r_oy[i] - (r_ox[i] >>> i);
                        r_oz[i+1] <= r_oz[i] + ATAN;
                    end
                    r_cf[i+1] <= r_cf[i];
                    r_ch[i+1] <= r_ch[i];
                end
            end
        end
    endgenerate

    // ---------------- sign fix and |sin(lat)| ----------------
    logic          r_pv;
    t_base         r_pbase;
    logic [DW-1:0] r_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= r_cv[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pbase.cl <= r_lx[CORDIC_STAGES];
            r_pbase.sl <= r_ly[CORDIC_STAGES];
            r_pbase.co <= r_cf[CORDIC_STAGES] ? DW'(0) - r_ox[CORDIC_STAGES]
                                              : r_ox[CORDIC_STAGES];
            r_pbase.so <= r_cf[CORDIC_STAGES] ? DW'(0) - r_oy[CORDIC_STAGES]
                                              : r_oy[CORDIC_STAGES];
            r_pbase.h  <= r_ch[CORDIC_STAGES];
            r_ms       <= r_ly[CORDIC_STAGES][DW-1] ? DW'(0) - r_ly[CORDIC_STAGES]
                                                    : r_ly[CORDIC_STAGES];
        end
    end

    // ---------------- 1 - e2 sin^2 ----------------
    logic          s2_v, q_v;
    logic [DW-1:0] s2_p, q_p;
    t_base         s2_base, q_base;

    g2e_mul #(.SHIFT(62), .SGN(1'b0), .SIDE_W($bits(t_base))) u_sin2 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_pv), .i_a(r_ms), .i_b(r_ms),
        .i_side(r_pbase), .o_valid(s2_v), .o_p(s2_p), .o_side(s2_base)
    );

    g2e_mul #(.SHIFT(62), .SGN(1'b0), .SIDE_W($bits(t_base))) u_e2s2 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(s2_v), .i_a(E2_Q62), .i_b(s2_p),
        .i_side(s2_base), .o_valid(q_v), .o_p(q_p), .o_side(q_base)
    );

    logic          r_mv;
    logic [DW-1:0] r_m;
    t_base         r_mbase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (en) begin
            r_mv <= q_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m     <= ONE_Q62 - q_p;
            r_mbase <= q_base;
        end
    end

    // ---------------- inverse square root, Newton steps ----------------
    logic [DW-1:0] w_y    [0:RSQRT_STEPS];
    logic [DW-1:0] w_m    [0:RSQRT_STEPS];
    t_base         w_base [0:RSQRT_STEPS];
    logic          w_v    [0:RSQRT_STEPS];

    assign w_y[0]    = ONE_Q62;
    assign w_m[0]    = r_m;
    assign w_base[0] = r_mbase;
    assign w_v[0]    = r_mv;

    generate
        for (genvar k = 0; k < RSQRT_STEPS; k++) begin : g_rsqrt
            t_rs_side      a_side_i, a_side_o, b_side_o, r_ws;
            t_rc_side      c_side_i, c_side_o;
            logic [DW-1:0] t_q, u_q, r_w;
            logic          a_v, b_v, r_wv;

            assign a_side_i = '{m: w_m[k], y: w_y[k], base: w_base[k]};

            g2e_mul #(.SHIFT(62), .SGN(1'b0), .SIDE_W($bits(t_rs_side))) u_ma (
                .i_clk, .i_rst_n, .i_en(en), .i_valid(w_v[k]), .i_a(w_y[k]),
                .i_b(w_y[k]), .i_side(a_side_i), .o_valid(a_v), .o_p(t_q),
                .o_side(a_side_o)
            );

            g2e_mul #(.SHIFT(62), .SGN(1'b0), .SIDE_W($bits(t_rs_side))) u_mb (
                .i_clk, .i_rst_n, .i_en(en), .i_valid(a_v), .i_a(a_side_o.m),
                .i_b(t_q), .i_side(a_side_o), .o_valid(b_v), .o_p(u_q),
                .o_side(b_side_o)
            );

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_wv <= 1'b0;
                end else if (en) begin
                    r_wv <= b_v;
                end
            end

            // clamp 3 - m*y^2 at zero
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_w  <= (u_q > THREE_Q62) ? '0 : THREE_Q62 - u_q;
                    r_ws <= b_side_o;
                end
            end

            assign c_side_i = '{m: r_ws.m, base: r_ws.base};

            g2e_mul #(.SHIFT(63), .SGN(1'b0), .SIDE_W($bits(t_rc_side))) u_mc (
                .i_clk, .i_rst_n, .i_en(en), .i_valid(r_wv), .i_a(r_ws.y),
                .i_b(r_w), .i_side(c_side_i), .o_valid(w_v[k+1]), .o_p(w_y[k+1]),
                .o_side(c_side_o)
            );

            assign w_m[k+1]    = c_side_o.m;
            assign w_base[k+1] = c_side_o.base;
        end
    endgenerate

    // ---------------- radii ----------------
    logic          r20_v, rz_v;
    logic [DW-1:0] r20_p, rz_p;
    t_base         r20_base;
    t_r20_side     rz_side_i, rz_side_o;

    g2e_mul #(.SHIFT(42), .SGN(1'b0), .SIDE_W($bits(t_base))) u_r20 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(w_v[RSQRT_STEPS]), .i_a(A_MM),
        .i_b(w_y[RSQRT_STEPS]), .i_side(w_base[RSQRT_STEPS]), .o_valid(r20_v),
        .o_p(r20_p), .o_side(r20_base)
    );

    assign rz_side_i = '{r20: r20_p, base: r20_base};

    g2e_mul #(.SHIFT(62), .SGN(1'b0), .SIDE_W($bits(t_r20_side))) u_rz (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r20_v), .i_a(r20_p), .i_b(E2_Q62),
        .i_side(rz_side_i), .o_valid(rz_v), .o_p(rz_p), .o_side(rz_side_o)
    );

    logic          r_sv;
    logic [DW-1:0] r_rh, r_scl;
    t_tm_side      r_sside;
    logic [DW-1:0] n_h20;

    assign n_h20 = {{16{rz_side_o.base.h[27]}}, rz_side_o.base.h, 20'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (en) begin
            r_sv <= rz_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rh        <= rz_side_o.r20 + n_h20;
            r_scl       <= rz_side_o.base.cl;
            r_sside.co  <= rz_side_o.base.co;
            r_sside.so  <= rz_side_o.base.so;
            r_sside.rzh <= rz_side_o.r20 - rz_p + n_h20;
            r_sside.sl  <= rz_side_o.base.sl;
        end
    end

    // ---------------- final products ----------------
    logic          tm_v, xm_v, ym_v, zm_v;
    logic [DW-1:0] tm_p, xm_p, ym_p, zm_p;
    t_tm_side      tm_side_o;
    t_xm_side      xm_side_i, xm_side_o;
    t_ym_side      ym_side_i, ym_side_o;
    t_zm_side      zm_side_i, zm_side_o;

    g2e_mul #(.SHIFT(62), .SGN(1'b1), .SIDE_W($bits(t_tm_side))) u_tm (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_sv), .i_a(r_rh), .i_b(r_scl),
        .i_side(r_sside), .o_valid(tm_v), .o_p(tm_p), .o_side(tm_side_o)
    );

    assign xm_side_i = '{t: tm_p, so: tm_side_o.so, rzh: tm_side_o.rzh, sl: tm_side_o.sl};

    g2e_mul #(.SHIFT(82), .SGN(1'b1), .SIDE_W($bits(t_xm_side))) u_xm (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(tm_v), .i_a(tm_p), .i_b(tm_side_o.co),
        .i_side(xm_side_i), .o_valid(xm_v), .o_p(xm_p), .o_side(xm_side_o)
    );

    assign ym_side_i = '{x: xm_p[33:0], rzh: xm_side_o.rzh, sl: xm_side_o.sl};

    g2e_mul #(.SHIFT(82), .SGN(1'b1), .SIDE_W($bits(t_ym_side))) u_ym (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(xm_v), .i_a(xm_side_o.t),
        .i_b(xm_side_o.so), .i_side(ym_side_i), .o_valid(ym_v), .o_p(ym_p),
        .o_side(ym_side_o)
    );

    assign zm_side_i = '{x: ym_side_o.x, y: ym_p[33:0]};

    g2e_mul #(.SHIFT(82), .SGN(1'b1), .SIDE_W($bits(t_zm_side))) u_zm (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(ym_v), .i_a(ym_side_o.rzh),
        .i_b(ym_side_o.sl), .i_side(zm_side_i), .o_valid(zm_v), .o_p(zm_p),
        .o_side(zm_side_o)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= zm_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_ecef_x <= zm_side_o.x;
            o_ecef_y <= zm_side_o.y;
            o_ecef_z <= zm_p[33:0];
        end
    end

    `G2E_ASSERT_IMP(a_stall_needs_result, o_stall, o_valid)
    `G2E_ASSERT_NXT(a_stall_freezes_entry, o_stall, $stable(r_cv[0]) && $stable(r_lz[0]))
    `G2E_ASSERT_IMP(a_lat_saturated, r_cv[0], (r_lz[0] <= Z_LIM) && (r_lz[0] >= -Z_LIM))
    `G2E_ASSERT_IMP(a_lon_folded, r_cv[0], (r_oz[0] <= Z_LIM) && (r_oz[0] >= -Z_LIM))

endmodule
`default_nettype wire

// ----- hdl/g2e_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
module g2e_mul
    import g2e_pkg::*;
#(
    parameter int SHIFT  = 62,
    parameter bit SGN    = 1'b0,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [DW-1:0]     i_a,
    input  wire logic [DW-1:0]     i_b,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [DW-1:0]          o_p,
    output logic [SIDE_W-1:0]      o_side
);

    localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (SHIFT - 1);

    logic              s0_v;
    logic [DW-1:0]     s0_a;
    logic [DW-1:0]     s0_b;
    logic              s0_neg;
    logic [SIDE_W-1:0] s0_side;

    logic              r1_v, r2_v, r3_v;
    logic [DW-1:0]     r1_p00, r1_p01, r1_p10, r1_p11;
    logic [DW:0]       r2_mid;
    logic [DW-1:0]     r2_lo, r2_hi;
    logic [DW-1:0]     r3_p;
    logic              r1_neg, r2_neg, r3_neg;
    logic [SIDE_W-1:0] r1_side, r2_side, r3_side;
    logic [PROD_W-1:0] n_full;

    generate
        if (SGN) begin : g_pre
            logic              r_v;
            logic [DW-1:0]     r_a;
            logic [DW-1:0]     r_b;
            logic              r_neg;
            logic [SIDE_W-1:0] r_side;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v <= 1'b0;
                end else if (i_en) begin
                    r_v <= i_valid;
                end
            end
            // take magnitudes, keep the sign of the product
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a    <= i_a[DW-1] ? DW'(0) - i_a : i_a;
                    r_b    <= i_b[DW-1] ? DW'(0) - i_b : i_b;
                    r_neg  <= i_a[DW-1] ^ i_b[DW-1];
                    r_side <= i_side;
                end
            end
            assign s0_v    = r_v;
            assign s0_a    = r_a;
            assign s0_b    = r_b;
            assign s0_neg  = r_neg;
            assign s0_side = r_side;
        end else begin : g_nopre
            assign s0_v    = i_valid;
            assign s0_a    = i_a;
            assign s0_b    = i_b;
            assign s0_neg  = 1'b0;
            assign s0_side = i_side;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= s0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    assign n_full = {r2_hi, r2_lo} + (PROD_W'(r2_mid) << HALF) + RND;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p00  <= DW'(s0_a[HALF-1:0]) * DW'(s0_b[HALF-1:0]);
            r1_p01  <= DW'(s0_a[HALF-1:0]) * DW'(s0_b[DW-1:HALF]);
            r1_p10  <= DW'(s0_a[DW-1:HALF]) * DW'(s0_b[HALF-1:0]);
            r1_p11  <= DW'(s0_a[DW-1:HALF]) * DW'(s0_b[DW-1:HALF]);
            r1_neg  <= s0_neg;
            r1_side <= s0_side;
            r2_mid  <= (DW + 1)'(r1_p01) + (DW + 1)'(r1_p10);
            r2_lo   <= r1_p00;
            r2_hi   <= r1_p11;
            r2_neg  <= r1_neg;
            r2_side <= r1_side;
            r3_p    <= DW'(n_full >> SHIFT);
            r3_neg  <= r2_neg;
            r3_side <= r2_side;
        end
    end

    generate
        if (SGN) begin : g_post
            logic              r_v;
            logic [DW-1:0]     r_p;
            logic [SIDE_W-1:0] r_side;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v <= 1'b0;
                end else if (i_en) begin
                    r_v <= r3_v;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_p    <= r3_neg ? DW'(0) - (r3_p & MASK63) : (r3_p & MASK63);
                    r_side <= r3_side;
                end
            end
            assign o_valid = r_v;
            assign o_p     = r_p;
            assign o_side  = r_side;
        end else begin : g_nopost
            assign o_valid = r3_v;
            assign o_p     = r3_p;
            assign o_side  = r3_side;
        end
    endgenerate

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import g2e_pkg::*;

    localparam int     STAGES    = 32;
    localparam int     LATENCY   = STAGES + 107;
    localparam int     IDLE_MAX  = 4000;
    localparam int     N_RANDOM  = 500;
    localparam longint POLE      = 64'sd1073741824;
    localparam longint HALF_TURN = 64'sd2147483648;
    localparam logic [63:0] Q62_ONE   = 64'd1 << 62;
    localparam logic [63:0] Q62_THREE = 64'd3 << 62;
    localparam logic [63:0] SEMI_MAJOR_MM = 64'd6378137000;
    localparam logic [127:0] ECC2_NUM = 128'd6694380004260827;
    localparam logic [127:0] ECC2_DEN = 128'd1000000000000000000;

    typedef struct packed {
        logic [33:0] x;
        logic [33:0] y;
        logic [33:0] z;
    } ecef_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_latitude;
    logic signed [31:0] i_longitude;
    logic signed [27:0] i_altitude;
    logic               o_valid;
    logic               i_stall;
    logic signed [33:0] o_ecef_x;
    logic signed [33:0] o_ecef_y;
    logic signed [33:0] o_ecef_z;

    geodetic_to_ecef_core #(.CORDIC_STAGES(STAGES)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_latitude(i_latitude),
        .i_longitude(i_longitude),
        .i_altitude(i_altitude),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_ecef_x(o_ecef_x),
        .o_ecef_y(o_ecef_y),
        .o_ecef_z(o_ecef_z)
    );

    ecef_t       pending_pos[$];
    int          n_errors;
    int          idle_cycles;
    int          burst_left;
    bit          valid_low;
    longint      arc_step[STAGES];
    logic [63:0] gain_comp;
    logic [63:0] ecc2_q62;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // round(a*b / 2^s), halves up, wraps at 128 bits
    function automatic logic [63:0] rnd_mul(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (s - 1));
        p = p >> s;
        return p[63:0];
    endfunction

    function automatic longint sgn_mul(input longint a, input longint b, input int s);
        bit          neg;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] r;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        r = rnd_mul(ua, ub, s) & 64'h7FFF_FFFF_FFFF_FFFF;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [63:0] inv_sqrt(input logic [63:0] m);
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] w;
        y = Q62_ONE;
        for (int k = 0; k < 7; k++) begin
            t = rnd_mul(y, y, 62);
            u = rnd_mul(m, t, 62);
            w = (u > Q62_THREE) ? 64'd0 : Q62_THREE - u;
            y = rnd_mul(y, w, 63);
        end
        return y;
    endfunction

    function automatic logic [63:0] atan_series(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        sum = 64'd0;
        for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
            term = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
            sum = (k % 2 == 1) ? sum - term : sum + term;
        end
        return sum;
    endfunction

    task automatic build_tables();
        logic [63:0]  third;
        logic [63:0]  a13;
        logic [63:0]  qpi;
        logic [63:0]  p;
        logic [127:0] q;
        int           k;
        third = Q62_ONE / 3;
        a13 = 64'd0;
        k = 0;
        while (third != 0) begin
            a13 = (k % 2 == 1) ? a13 - third / (2 * k + 1) : a13 + third / (2 * k + 1);
            third = third / 9;
            k++;
        end
        qpi = atan_series(1) + a13;
        p = 64'd1 << 60;
        for (int i = 0; i < STAGES; i++) begin
            if (i == 0) begin
                arc_step[i] = 64'sd1 <<< 59;
            end else begin
                q = ({64'd0, atan_series(i)} << 60) / {64'd0, qpi};
                arc_step[i] = longint'((q[63:0] + 64'd1) >> 1);
            end
            if (2 * i < 64)
                p = p + (p >> (2 * i));
        end
        gain_comp = (inv_sqrt(p) + 64'd1) >> 1;
        q = (ECC2_NUM << 63) / ECC2_DEN;
        ecc2_q62 = (q[63:0] + 64'd1) >> 1;
    endtask

    task automatic cordic_sincos(input longint angle, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = longint'(gain_comp);
        y = 0;
        z = angle;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arc_step[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arc_step[i];
            end
        end
        c = x;
        s = y;
    endtask

    task automatic geo_to_ecef(input logic signed [31:0] lat_in,
                               input logic signed [31:0] lon_in,
                               input logic signed [27:0] alt_in, output ecef_t pos);
        longint      lat;
        longint      lon;
        longint      h;
        longint      sl;
        longint      cl;
        longint      so;
        longint      co;
        longint      r20;
        longint      rz20;
        longint      t;
        logic [63:0] ms;
        logic [63:0] m;
        logic [63:0] r;
        bit          flip;
        lat = lat_in;
        lon = lon_in;
        h = alt_in;
        flip = 1'b0;
        // clamp latitude to the poles
        if (lat > POLE)
            lat = POLE;
        if (lat < -POLE)
            lat = -POLE;
        // fold the back half of longitude and negate afterwards
        if (lon > POLE) begin
            lon = lon - HALF_TURN;
            flip = 1'b1;
        end else if (lon < -POLE) begin
            lon = lon + HALF_TURN;
            flip = 1'b1;
        end
        cordic_sincos(lat <<< 30, cl, sl);
        cordic_sincos(lon <<< 30, co, so);
        if (flip) begin
            co = -co;
            so = -so;
        end
        ms = (sl < 0) ? -sl : sl;
        m = Q62_ONE - rnd_mul(ecc2_q62, rnd_mul(ms, ms, 62), 62);
        r = rnd_mul(SEMI_MAJOR_MM, inv_sqrt(m), 42);
        r20 = longint'(r);
        rz20 = r20 - longint'(rnd_mul(r, ecc2_q62, 62));
        t = sgn_mul(r20 + h * 1048576, cl, 62);
        pos.x = 34'(sgn_mul(t, co, 82));
        pos.y = 34'(sgn_mul(t, so, 82));
        pos.z = 34'(sgn_mul(rz20 + h * 1048576, sl, 82));
    endtask

    // drive one item and hold it until taken
    task automatic send_item(input logic signed [31:0] lat, input logic signed [31:0] lon,
                             input logic signed [27:0] alt);
        ecef_t pos;
        i_valid     <= 1'b1;
        i_latitude  <= lat;
        i_longitude <= lon;
        i_altitude  <= alt;
        valid_low = 1'b0;
        do @(posedge i_clk); while (o_stall);
        geo_to_ecef(lat, lon, alt, pos);
        pending_pos.push_back(pos);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            valid_low = 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 15);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drop_valid();
        if (!valid_low)
            i_valid <= 1'b0;
        valid_low = 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic signed [31:0] lats[8];
        logic signed [31:0] lons[8];
        logic signed [27:0] alts[6];
        lats = '{32'sh4000_0000, -32'sh4000_0000, 0, 32'sh4000_0001, -32'sh4000_0001,
                 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh2000_0000};
        lons = '{0, 32'sh4000_0000, -32'sh4000_0000, 32'sh4000_0001, -32'sh4000_0001,
                 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh6000_0000};
        alts = '{0, 28'sd100000000, -28'sd100000000, 28'sh7FF_FFFF, 28'sh800_0000,
                 28'sd1234};
        for (int i = 0; i < 8; i++)
            send_item(lats[i], lons[i], alts[i % 6]);
        for (int i = 0; i < 8; i++)
            send_item(lats[(i + 3) % 8], lons[i], alts[(i + 1) % 6]);
        send_item(32'sh4000_0000, 32'sh8000_0000, 28'sh800_0000);
        send_item(-32'sh4000_0000, 32'sh7FFF_FFFF, 28'sh7FF_FFFF);
    endtask

    task automatic test_random(input int count);
        logic signed [31:0] lat;
        logic signed [31:0] alt32;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0)
                lat = $urandom;
            else
                lat = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
            if ($urandom_range(0, 9) == 0)
                alt32 = $urandom;
            else
                alt32 = $urandom_range(0, 200000000) - 100000000;
            send_item(lat, $urandom, alt32[27:0]);
        end
    endtask

    // hold off input until the pipe has drained
    task automatic test_drain();
        drop_valid();
        while (pending_pos.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        ecef_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pos.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected item: x=%0d y=%0d z=%0d", o_ecef_x, o_ecef_y,
                             o_ecef_z);
            end else begin
                want = pending_pos.pop_front();
                if (want.x !== o_ecef_x || want.y !== o_ecef_y || want.z !== o_ecef_z) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("bad item: want x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                 $signed(want.x), $signed(want.y), $signed(want.z),
                                 o_ecef_x, o_ecef_y, o_ecef_z);
                end
            end
        end
    end

    // receiver stall pattern: runs of free flow, random and periodic stalls
    always @(posedge i_clk) begin
        int mode;
        int phase;
        if (phase == 0) begin
            mode = $urandom_range(0, 3);
            phase = $urandom_range(20, 150);
        end
        phase--;
        case (mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 1) == 1);
            2: i_stall <= (phase % 4 == 0);
            default: i_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_MAX) begin
            $display("geodetic_to_ecef_core: mismatch");
            $finish;
        end
    end

    initial begin
        n_errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        valid_low = 1'b1;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_stall     <= 1'b0;
        i_latitude  <= '0;
        i_longitude <= '0;
        i_altitude  <= '0;
        build_tables();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(N_RANDOM / 2);
        test_drain();
        test_random(N_RANDOM / 2);
        drop_valid();
        while (pending_pos.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0)
            $display("geodetic_to_ecef_core: match");
        else
            $display("geodetic_to_ecef_core: mismatch");
        $finish;
    end
endmodule
